>>> design/sqtl_pkg.sv
package sqtl_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned QUERY_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OCC_W   = 5;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ID_W-1:0]    entry_id;
    logic [TIME_W-1:0]  service_time;
    logic [QUERY_W-1:0] query_time;
    logic               query_zero;
  } cmd_t;

endpackage

>>> design/sqtl_if.sv
interface sqtl_in_if;
  import sqtl_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [ID_W-1:0]    entry_id;
  logic [TIME_W-1:0]  service_time;
  logic [QUERY_W-1:0] query_time;

  modport source (output valid, op, entry_id, service_time, query_time, input ready);
  modport sink   (input valid, op, entry_id, service_time, query_time, output ready);
endinterface

interface sqtl_out_if;
  import sqtl_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   result_id;
  logic [TIME_W-1:0] result_time;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, status, result_id, result_time, occupancy, input ready);
  modport sink   (input valid, status, result_id, result_time, occupancy, output ready);
endinterface

>>> design/service_queue_with_time_lookup.sv
// Enqueue, dequeue, a peek on an empty queue and an immediate find miss (zero query or
// empty queue) are answered from the idle state; a peek reads the front entry in S_PEEK,
// and a find walks the stored entries in S_FIND until a hit or the last entry.
// The back end runs one operation at a time: it takes no new command while one is in progress.
// Reset (rst, synchronous) empties the queue and the command buffer; stored entries
// are not cleared and are only read once written.
module service_queue_with_time_lookup
  import sqtl_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  sqtl_in_if.sink    req,
  sqtl_out_if.source rsp
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  sqtl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  sqtl_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp       (rsp)
  );

endmodule

>>> design/sqtl_ram.sv
module sqtl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/sqtl_front.sv
module sqtl_front
  import sqtl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  sqtl_in_if.sink    req,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_ready
);

  cmd_t       slot [2];
  logic       head;
  logic       tail;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       incoming;

  always_comb begin
    incoming.op           = req.op;
    incoming.entry_id     = req.entry_id;
    incoming.service_time = req.service_time;
    incoming.query_time   = req.query_time;
    incoming.query_zero   = (req.query_time == '0);
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = slot[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[tail] <= incoming;
    end
    if (rst) begin
      head <= 1'b0;
      tail <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |-> (head == tail))
    else $error("front queue full with head and tail apart");
  assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0) |-> (head == tail))
    else $error("front queue empty with head and tail apart");
  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_ready) |=> cmd_valid)
    else $error("stalled command lost from front queue");

endmodule

>>> design/sqtl_back.sv
module sqtl_back
  import sqtl_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  sqtl_out_if.source rsp
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MEM_W = ID_W + TIME_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PEEK = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;

  logic [1:0]         state;
  logic [PTR_W-1:0]   front_ptr;
  logic [PTR_W-1:0]   rear_ptr;
  logic [PTR_W-1:0]   walk_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   left;
  logic [QUERY_W-1:0] remaining;

  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [ID_W-1:0]    out_id;
  logic [TIME_W-1:0]  out_time;
  logic [OCC_W-1:0]   out_occ;

  logic               out_free;
  logic               start;
  logic               done;
  logic               full;
  logic               empty;
  logic               mem_we;
  logic [PTR_W-1:0]   rd_addr;
  logic [MEM_W-1:0]   rd_data;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_W-1:0]  rd_time;
  logic [CNT_W-1:0]   count_inc;
  logic [CNT_W-1:0]   count_dec;
  logic [CNT_W+OCC_W-1:0] occ_now_x;
  logic [CNT_W+OCC_W-1:0] occ_inc_x;
  logic [CNT_W+OCC_W-1:0] occ_dec_x;
  logic               hit;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign out_free  = !out_valid || rsp.ready;
  assign start     = (state == S_IDLE) && cmd_valid && out_free;
  assign cmd_ready = start;
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign mem_we    = start && (cmd.op == OP_ENQUEUE) && !full;
  assign rd_addr   = (state == S_FIND) ? walk_ptr : front_ptr;
  assign rd_id     = rd_data[MEM_W-1:TIME_W];
  assign rd_time   = rd_data[TIME_W-1:0];
  assign count_inc = count + CNT_W'(1);
  assign count_dec = count - CNT_W'(1);
  assign occ_now_x = {OCC_W'(0), count};
  assign occ_inc_x = {OCC_W'(0), count_inc};
  assign occ_dec_x = {OCC_W'(0), count_dec};
  assign hit       = ({{(QUERY_W-TIME_W){1'b0}}, rd_time} >= remaining);

  always_comb begin
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd.op)
            OP_PEEK: done = empty;
            OP_FIND: done = empty || cmd.query_zero;
            default: done = 1'b1;
          endcase
        end
      end
      S_PEEK: done = 1'b1;
      S_FIND: done = hit || (left == CNT_W'(1));
      default: done = 1'b0;
    endcase
  end

  sqtl_ram #(
    .WIDTH (MEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (rear_ptr),
    .wdata ({cmd.entry_id, cmd.service_time}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.result_id   = out_id;
  assign rsp.result_time = out_time;
  assign rsp.occupancy   = out_occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_ptr <= '0;
      rear_ptr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= done || (out_valid && !rsp.ready);
      case (state)
        S_IDLE: begin
          if (start) begin
            out_id   <= '0;
            out_time <= '0;
            case (cmd.op)
              OP_ENQUEUE: begin
                if (full) begin
                  out_status <= ST_FULL;
                  out_occ    <= occ_now_x[OCC_W-1:0];
                end else begin
                  out_status <= ST_OK;
                  out_occ    <= occ_inc_x[OCC_W-1:0];
                  rear_ptr   <= wrap_inc(rear_ptr);
                  count      <= count_inc;
                end
              end
              OP_DEQUEUE: begin
                if (empty) begin
                  out_status <= ST_EMPTY;
                  out_occ    <= occ_now_x[OCC_W-1:0];
                end else begin
                  out_status <= ST_OK;
                  out_occ    <= occ_dec_x[OCC_W-1:0];
                  front_ptr  <= wrap_inc(front_ptr);
                  count      <= count_dec;
                end
              end
              OP_PEEK: begin
                out_occ <= occ_now_x[OCC_W-1:0];
                if (empty) begin
                  out_status <= ST_EMPTY;
                end else begin
                  state <= S_PEEK;
                end
              end
              default: begin
                out_occ <= occ_now_x[OCC_W-1:0];
                if (empty || cmd.query_zero) begin
                  out_status <= ST_NOT_FOUND;
                end else begin
                  walk_ptr  <= wrap_inc(front_ptr);
                  remaining <= cmd.query_time;
                  left      <= count;
                  state     <= S_FIND;
                end
              end
            endcase
          end
        end
        S_PEEK: begin
          out_status <= ST_OK;
          out_id     <= rd_id;
          out_time   <= rd_time;
          state      <= S_IDLE;
        end
        S_FIND: begin
          walk_ptr <= wrap_inc(walk_ptr);
          if (hit) begin
            out_status <= ST_OK;
            out_id     <= rd_id;
            state      <= S_IDLE;
          end else begin
            remaining <= remaining - {{(QUERY_W-TIME_W){1'b0}}, rd_time};
            left      <= left - CNT_W'(1);
            if (left == CNT_W'(1)) begin
              out_status <= ST_NOT_FOUND;
              state      <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) |-> (!out_valid && left != '0 && remaining != '0))
    else $error("find walk running with a pending result or nothing left");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PEEK) |-> (!out_valid && !empty))
    else $error("peek in progress with a pending result or an empty queue");
  assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (count == $past(count) + CNT_W'(1)))
    else $error("enqueue write without count advance");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd_ready)
    else $error("command taken while an operation is in progress");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sqtl_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   result_id;
    logic [TIME_W-1:0] result_time;
    logic [OCC_W-1:0]  occupancy;
  } service_outcome_t;

  class service_queue_shadow;
    logic [ID_W-1:0]   ids   [QUEUE_DEPTH];
    logic [TIME_W-1:0] times [QUEUE_DEPTH];
    int unsigned       front_idx;
    int unsigned       rear_idx;
    int unsigned       count;
    int unsigned       failures;
    service_outcome_t  pending_results[$];

    function new();
      front_idx = 0;
      rear_idx  = 0;
      count     = 0;
      failures  = 0;
    endfunction

    function logic [QUERY_W-1:0] prefix_time(int unsigned k);
      logic [QUERY_W-1:0] sum;
      sum = '0;
      for (int unsigned i = 0; i < k; i++) begin
        sum += times[(front_idx + i) % QUEUE_DEPTH];
      end
      return sum;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [TIME_W-1:0] svc, logic [QUERY_W-1:0] query);
      service_outcome_t   res;
      logic [QUERY_W-1:0] remaining;
      int unsigned        p;
      bit                 found;
      res = '{status: ST_OK, result_id: '0, result_time: '0, occupancy: '0};
      case (op)
        OP_ENQUEUE: begin
          if (count >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            ids[rear_idx]   = id;
            times[rear_idx] = svc;
            rear_idx = (rear_idx + 1) % QUEUE_DEPTH;
            count++;
          end
        end
        OP_DEQUEUE: begin
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            front_idx = (front_idx + 1) % QUEUE_DEPTH;
            count--;
          end
        end
        OP_PEEK: begin
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.result_id   = ids[front_idx];
            res.result_time = times[front_idx];
          end
        end
        default: begin
          remaining = query;
          p = front_idx;
          found = 1'b0;
          for (int unsigned k = 0; k < count && remaining != 0; k++) begin
            if (QUERY_W'(times[p]) >= remaining) begin
              found = 1'b1;
              res.result_id = ids[p];
              remaining = '0;
            end else begin
              remaining -= QUERY_W'(times[p]);
            end
            p = (p + 1) % QUEUE_DEPTH;
          end
          if (!found) begin
            res.status    = ST_NOT_FOUND;
            res.result_id = '0;
          end
        end
      endcase
      res.occupancy = OCC_W'(count);
      pending_results.push_back(res);
    endfunction

    function void check_result(service_outcome_t got);
      service_outcome_t want;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: result with no transaction pending, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        failures++;
        $display("%0t: status expected %h actual %h", $time, want.status, got.status);
      end
      if (got.result_id !== want.result_id) begin
        failures++;
        $display("%0t: result_id expected %h actual %h", $time, want.result_id,
                 got.result_id);
      end
      if (got.result_time !== want.result_time) begin
        failures++;
        $display("%0t: result_time expected %h actual %h", $time, want.result_time,
                 got.result_time);
      end
      if (got.occupancy !== want.occupancy) begin
        failures++;
        $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                 got.occupancy);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  service_queue_shadow shadow = new();

  sqtl_in_if  req_if ();
  sqtl_out_if rsp_if ();

  service_queue_with_time_lookup #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] svc,
                              input logic [QUERY_W-1:0] query);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.entry_id     <= id;
    req_if.service_time <= svc;
    req_if.query_time   <= query;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    shadow.note_request(op, id, svc, query);
  endtask

  task automatic run_directed();
    send_request(OP_PEEK, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(OP_DEQUEUE, ID_W'($urandom), TIME_W'($urandom), $urandom);
    send_request(OP_FIND, ID_W'($urandom), TIME_W'($urandom), 32'd5);
    send_request(OP_ENQUEUE, 16'hFFFF, 16'h0000, 32'h0000_0000);
    send_request(OP_ENQUEUE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    for (int unsigned i = 2; i < QUEUE_DEPTH; i++) begin
      send_request(OP_ENQUEUE, ID_W'($urandom), TIME_W'($urandom_range(1, 9)), $urandom);
    end
    send_request(OP_ENQUEUE, 16'hA5A5, 16'h5A5A, $urandom);
    send_request(OP_PEEK, ID_W'($urandom), TIME_W'($urandom), $urandom);
    send_request(OP_FIND, ID_W'($urandom), TIME_W'($urandom), 32'h0000_0000);
    send_request(OP_FIND, ID_W'($urandom), TIME_W'($urandom), 32'hFFFF_FFFF);
    send_request(OP_FIND, ID_W'($urandom), TIME_W'($urandom), 32'h0000_0001);
    send_request(OP_DEQUEUE, ID_W'($urandom), TIME_W'($urandom), $urandom);
  endtask

  task automatic run_random(int unsigned n);
    int unsigned        enq_pct;
    int unsigned        pick;
    int unsigned        k;
    logic [OP_W-1:0]    op;
    logic [TIME_W-1:0]  svc;
    logic [QUERY_W-1:0] query;
    enq_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 30 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 80;
          1: enq_pct = 20;
          default: enq_pct = 50;
        endcase
      end
      if ($urandom_range(99) < enq_pct) begin
        op = OP_ENQUEUE;
      end else begin
        pick = $urandom_range(9);
        if (pick < 4) op = OP_DEQUEUE;
        else if (pick < 6) op = OP_PEEK;
        else op = OP_FIND;
      end
      case ($urandom_range(3))
        0: svc = '0;
        1: svc = TIME_W'($urandom_range(1, 20));
        2: svc = TIME_W'($urandom);
        default: svc = $urandom_range(1) ? 16'hFFFF : 16'd1;
      endcase
      k = $urandom_range(shadow.count);
      case ($urandom_range(6))
        0: query = '0;
        1: query = shadow.prefix_time(k);
        2: query = shadow.prefix_time(k) + 1;
        3: query = shadow.prefix_time(k) - 1;
        4: query = $urandom;
        5: query = $urandom_range(1, 100);
        default: query = shadow.prefix_time(shadow.count);
      endcase
      send_request(op, ID_W'($urandom), svc, query);
    end
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        shadow.check_result('{status: rsp_if.status, result_id: rsp_if.result_id,
                              result_time: rsp_if.result_time,
                              occupancy: rsp_if.occupancy});
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    req_if.valid        = 1'b0;
    req_if.op           = OP_ENQUEUE;
    req_if.entry_id     = '0;
    req_if.service_time = '0;
    req_if.query_time   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 31;
    recv_idle_pct = 70;
    run_directed();
    run_random(267);

    send_idle_pct = 70;
    recv_idle_pct = 31;
    run_random(267);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(266);
    req_if.valid <= 1'b0;

    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (QUEUE_DEPTH + 8) @(posedge clk);
    if (shadow.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
